/* sv/console_mouse_serial_responder_assert.svh */
// assertion macros shared by the responder rtl
`ifndef CONSOLE_MOUSE_SERIAL_RESPONDER_ASSERT_SVH
`define CONSOLE_MOUSE_SERIAL_RESPONDER_ASSERT_SVH

// condition in this cycle implies consequence in the same cycle
`define CMSR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition in this cycle implies consequence in the next cycle
`define CMSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/cmsr_pkg.sv */
package cmsr_pkg;

   localparam logic [1:0] OP_REPORT = 2'd0;
   localparam logic [1:0] OP_CMD    = 2'd1;
   localparam logic [1:0] OP_ATTN   = 2'd2;

   localparam logic [7:0] BYTE_ADDR     = 8'h01;
   localparam logic [7:0] BYTE_READ     = 8'h42;
   localparam logic [7:0] BYTE_ID       = 8'h12;
   localparam logic [7:0] BYTE_READY    = 8'h5A;
   localparam logic [7:0] BYTE_RELEASED = 8'hFF;

   typedef struct packed {
      logic [1:0]        op;
      logic [1:0]        report_buttons;
      logic signed [7:0] report_dx;
      logic signed [7:0] report_dy;
      logic [7:0]        cmd_byte;
   } req_type;

   typedef struct packed {
      logic       ack;
      logic [7:0] tx_byte;
      logic       led;
      logic       frame_done;
   } rsp_type;

   typedef struct packed {
      logic report_en;
      logic latch_en;
   } motion_ctl_type;

   typedef struct packed {
      logic       live_left;
      logic       live_right;
      logic       held_left;
      logic [7:0] held_x;
      logic [7:0] held_y;
   } motion_status_type;

   // signed 8-bit add clamped to -128..127
   function automatic logic [7:0] sat_add8(input logic [7:0] a, input logic [7:0] b);
      logic signed [8:0] sum;
      logic [7:0]        res;
      sum = $signed({a[7], a}) + $signed({b[7], b});
      if (sum > 9'sd127) begin
         res = 8'h7F;
      end else if (sum < -9'sd128) begin
         res = 8'h80;
      end else begin
         res = sum[7:0];
      end
      return res;
   endfunction

endpackage

/* sv/cmsr_motion.sv */
module cmsr_motion
   import cmsr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  motion_ctl_type    ctl,
   input  logic [1:0]        report_buttons,
   input  logic signed [7:0] report_dx,
   input  logic signed [7:0] report_dy,
   output motion_status_type status
);

   logic [7:0] acc_x_ff, acc_x_in;
   logic [7:0] acc_y_ff, acc_y_in;
   logic       live_left_ff, live_left_in;
   logic       live_right_ff, live_right_in;
   logic       held_left_ff, held_left_in;
   logic       held_right_ff, held_right_in;
   logic [7:0] held_x_ff, held_x_in;
   logic [7:0] held_y_ff, held_y_in;

   always_comb begin
      acc_x_in      = acc_x_ff;
      acc_y_in      = acc_y_ff;
      live_left_in  = live_left_ff;
      live_right_in = live_right_ff;
      held_left_in  = held_left_ff;
      held_right_in = held_right_ff;
      held_x_in     = held_x_ff;
      held_y_in     = held_y_ff;
      if (ctl.report_en) begin
         acc_x_in      = sat_add8(acc_x_ff, report_dx);
         acc_y_in      = sat_add8(acc_y_ff, report_dy);
         live_left_in  = report_buttons[0];
         live_right_in = report_buttons[1];
      end else if (ctl.latch_en) begin
         // snapshot for the frame, then start collecting afresh
         held_x_in     = acc_x_ff;
         held_y_in     = acc_y_ff;
         held_left_in  = live_left_ff;
         held_right_in = live_right_ff;
         acc_x_in      = 8'h00;
         acc_y_in      = 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_x_ff      <= 8'h00;
         acc_y_ff      <= 8'h00;
         live_left_ff  <= 1'b0;
         live_right_ff <= 1'b0;
         held_left_ff  <= 1'b0;
         held_right_ff <= 1'b0;
         held_x_ff     <= 8'h00;
         held_y_ff     <= 8'h00;
      end else begin
         acc_x_ff      <= acc_x_in;
         acc_y_ff      <= acc_y_in;
         live_left_ff  <= live_left_in;
         live_right_ff <= live_right_in;
         held_left_ff  <= held_left_in;
         held_right_ff <= held_right_in;
         held_x_ff     <= held_x_in;
         held_y_ff     <= held_y_in;
      end
   end

   assign status.live_left  = live_left_ff;
   assign status.live_right = live_right_ff;
   assign status.held_left  = held_left_ff;
   assign status.held_x     = held_x_ff;
   assign status.held_y     = held_y_ff;

endmodule

/* sv/console_mouse_serial_responder.sv */
// Device side of a console mouse link, one event per item: mouse reports fold
// into saturating 8-bit motion accumulators, command bytes step the seven-byte
// read frame (address, read, then id, 0x5A, 0xFF, inverted buttons, dx, dy),
// and attention release restarts it. Every item gives exactly one result with
// the ack flag, the byte to drive next, the LED level and a frame-done flag.
// Item handling is registered: the frame state and motion registers are
// updated at acceptance and the result lands in an output register. req_ready
// is high whenever that register is empty or being taken in the same cycle,
// so a new item enters every cycle as long as results are drained.
`include "console_mouse_serial_responder_assert.svh"

module console_mouse_serial_responder
   import cmsr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [2:0] {
      PH_ADDR  = 3'd0,
      PH_CMD   = 3'd1,
      PH_ID    = 3'd2,
      PH_LATCH = 3'd3,
      PH_X     = 3'd4,
      PH_Y     = 3'd5,
      PH_LAST  = 3'd6,
      PH_IDLE  = 3'd7
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [7:0]        next_tx_ff, next_tx_in;
   logic              led_pending_ff, led_pending_in;
   logic              led_level_ff, led_level_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic              req_accept;
   logic              ack;
   logic              done;
   motion_ctl_type    motion_ctl;
   motion_status_type motion_status;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   cmsr_motion u_motion (
      .clock          (clock),
      .reset          (reset),
      .ctl            (motion_ctl),
      .report_buttons (req_data.report_buttons),
      .report_dx      (req_data.report_dx),
      .report_dy      (req_data.report_dy),
      .status         (motion_status)
   );

   always_comb begin
      phase_in       = phase_ff;
      next_tx_in     = next_tx_ff;
      led_pending_in = led_pending_ff;
      led_level_in   = led_level_ff;
      ack            = 1'b0;
      done           = 1'b0;
      motion_ctl     = '0;
      if (req_accept) begin
         case (req_data.op)
            OP_REPORT: begin
               motion_ctl.report_en = 1'b1;
            end
            OP_ATTN: begin
               if (led_pending_ff) begin
                  led_level_in   = motion_status.held_left;
                  led_pending_in = 1'b0;
               end
               phase_in   = PH_ADDR;
               next_tx_in = BYTE_RELEASED;
            end
            OP_CMD: begin
               case (phase_ff)
                  PH_ADDR: begin
                     if (req_data.cmd_byte == BYTE_ADDR) begin
                        ack        = 1'b1;
                        phase_in   = PH_CMD;
                        next_tx_in = BYTE_ID;
                     end else begin
                        phase_in   = PH_IDLE;
                        next_tx_in = BYTE_RELEASED;
                     end
                  end
                  PH_CMD: begin
                     if (req_data.cmd_byte == BYTE_READ) begin
                        ack        = 1'b1;
                        phase_in   = PH_ID;
                        next_tx_in = BYTE_READY;
                     end else begin
                        phase_in   = PH_IDLE;
                        next_tx_in = BYTE_RELEASED;
                     end
                  end
                  PH_ID: begin
                     ack        = 1'b1;
                     phase_in   = PH_LATCH;
                     next_tx_in = BYTE_RELEASED;
                  end
                  PH_LATCH: begin
                     // button byte is active low: left on bit 3, right on bit 2
                     motion_ctl.latch_en = 1'b1;
                     ack        = 1'b1;
                     phase_in   = PH_X;
                     next_tx_in = ~{4'b0000, motion_status.live_left,
                                    motion_status.live_right, 2'b11};
                  end
                  PH_X: begin
                     ack        = 1'b1;
                     phase_in   = PH_Y;
                     next_tx_in = motion_status.held_x;
                  end
                  PH_Y: begin
                     ack        = 1'b1;
                     phase_in   = PH_LAST;
                     next_tx_in = motion_status.held_y;
                  end
                  PH_LAST: begin
                     done           = 1'b1;
                     led_pending_in = 1'b1;
                     phase_in       = PH_IDLE;
                     next_tx_in     = BYTE_RELEASED;
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_in.ack        = ack;
      rsp_in.tx_byte    = next_tx_in;
      rsp_in.led        = led_level_in;
      rsp_in.frame_done = done;
      rsp_valid_in      = req_accept || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         next_tx_ff     <= BYTE_RELEASED;
         led_pending_ff <= 1'b0;
         led_level_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         next_tx_ff     <= next_tx_in;
         led_pending_ff <= led_pending_in;
         led_level_ff   <= led_level_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      if (req_accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `CMSR_ASSERT_SAME(a_ack_not_done, clock, reset, rsp_valid_ff, !(rsp_ff.ack && rsp_ff.frame_done), "ack and frame_done together")
   `CMSR_ASSERT_SAME(a_done_released, clock, reset, rsp_valid_ff && rsp_ff.frame_done, rsp_ff.tx_byte == BYTE_RELEASED, "data line not released after last byte")
   `CMSR_ASSERT_SAME(a_idle_released, clock, reset, phase_ff == PH_IDLE, next_tx_ff == BYTE_RELEASED, "waiting for attention with data line driven")
   `CMSR_ASSERT_SAME(a_stall_blocks, clock, reset, rsp_valid_ff && !rsp_ready, !req_ready, "item taken while result register is held")
   `CMSR_ASSERT_NEXT(a_done_pending, clock, reset, req_accept && done, led_pending_ff, "completed frame did not arm the led update")

endmodule

/* dv/tb_top.sv */
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import cmsr_pkg::*;

   localparam logic [1:0] OP_UNUSED    = 2'd3;
   localparam logic [2:0] POS_WAIT     = 3'd7;
   localparam int         CLK_PERIOD   = 10;
   localparam int         MAX_WAIT     = 5;
   localparam int         RANDOM_ITEMS = 1200;
   localparam int         DRAIN_CYCLES = 10;
   localparam int         LIMIT_NS     = 2_000_000;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   console_mouse_serial_responder uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // mirror of the responder state
   logic [7:0] sum_x, sum_y;
   logic       btn_left, btn_right;
   logic       snap_left, snap_right;
   logic [7:0] snap_x, snap_y;
   logic [2:0] frame_pos;
   logic       led_armed, led_out;
   logic [7:0] drive_byte;

   rsp_type expected_replies[$];
   bit      idling_on;
   int      items_sent;
   int      items_effective;
   int      replies_checked;
   int      reads_completed;
   int      reads_aborted;
   int      error_count;

   task automatic clear_predictor();
      sum_x      = '0;
      sum_y      = '0;
      btn_left   = 1'b0;
      btn_right  = 1'b0;
      snap_left  = 1'b0;
      snap_right = 1'b0;
      snap_x     = '0;
      snap_y     = '0;
      frame_pos  = POS_WAIT;
      led_armed  = 1'b0;
      led_out    = 1'b0;
      drive_byte = BYTE_RELEASED;
   endtask

   function automatic logic [7:0] clamp_add(input logic [7:0] total, input logic [7:0] delta);
      int s;
      s = int'($signed(total)) + int'($signed(delta));
      if (s > 127) begin
         s = 127;
      end else if (s < -128) begin
         s = -128;
      end
      return s[7:0];
   endfunction

   function automatic void drop_frame();
      frame_pos  = POS_WAIT;
      drive_byte = BYTE_RELEASED;
      reads_aborted++;
   endfunction

   function automatic rsp_type step_responder(input req_type item);
      rsp_type reply;
      logic    ack;
      logic    done;
      ack  = 1'b0;
      done = 1'b0;
      if (!(item.op == OP_UNUSED || (item.op == OP_CMD && frame_pos == POS_WAIT))) begin
         items_effective++;
      end
      case (item.op)
         OP_REPORT: begin
            sum_x     = clamp_add(sum_x, item.report_dx);
            sum_y     = clamp_add(sum_y, item.report_dy);
            btn_left  = item.report_buttons[0];
            btn_right = item.report_buttons[1];
         end
         OP_ATTN: begin
            if (led_armed) begin
               led_out   = snap_left;
               led_armed = 1'b0;
            end
            if (frame_pos != POS_WAIT && frame_pos != 3'd0) begin
               reads_aborted++;
            end
            frame_pos  = 3'd0;
            drive_byte = BYTE_RELEASED;
         end
         OP_CMD: begin
            case (frame_pos)
               3'd0: begin
                  if (item.cmd_byte == BYTE_ADDR) begin
                     ack        = 1'b1;
                     frame_pos  = 3'd1;
                     drive_byte = BYTE_ID;
                  end else begin
                     drop_frame();
                  end
               end
               3'd1: begin
                  if (item.cmd_byte == BYTE_READ) begin
                     ack        = 1'b1;
                     frame_pos  = 3'd2;
                     drive_byte = BYTE_READY;
                  end else begin
                     drop_frame();
                  end
               end
               3'd2: begin
                  ack        = 1'b1;
                  frame_pos  = 3'd3;
                  drive_byte = BYTE_RELEASED;
               end
               3'd3: begin
                  // latch motion and buttons, then restart accumulation
                  snap_x     = sum_x;
                  snap_y     = sum_y;
                  sum_x      = '0;
                  sum_y      = '0;
                  snap_left  = btn_left;
                  snap_right = btn_right;
                  ack        = 1'b1;
                  frame_pos  = 3'd4;
                  drive_byte = ~{4'h0, snap_left, snap_right, 2'b11};
               end
               3'd4: begin
                  ack        = 1'b1;
                  frame_pos  = 3'd5;
                  drive_byte = snap_x;
               end
               3'd5: begin
                  ack        = 1'b1;
                  frame_pos  = 3'd6;
                  drive_byte = snap_y;
               end
               3'd6: begin
                  done       = 1'b1;
                  led_armed  = 1'b1;
                  frame_pos  = POS_WAIT;
                  drive_byte = BYTE_RELEASED;
                  reads_completed++;
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
      reply.ack        = ack;
      reply.tx_byte    = drive_byte;
      reply.led        = led_out;
      reply.frame_done = done;
      return reply;
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
      error_count++;
   endtask

   // every field but op is random; the caller overrides what matters
   function automatic req_type random_item(input logic [1:0] op);
      req_type item;
      item.op             = op;
      item.report_buttons = 2'($urandom_range(0, 3));
      item.report_dx      = 8'($urandom_range(0, 255));
      item.report_dy      = 8'($urandom_range(0, 255));
      item.cmd_byte       = 8'($urandom_range(0, 255));
      return item;
   endfunction

   function automatic req_type random_report();
      req_type item;
      item = random_item(OP_REPORT);
      // lean on the extremes so the accumulators saturate often
      if ($urandom_range(0, 2) == 0) begin
         item.report_dx = $urandom_range(0, 1) ? 8'h7F : 8'h80;
      end
      if ($urandom_range(0, 2) == 0) begin
         item.report_dy = $urandom_range(0, 1) ? 8'h7F : 8'h80;
      end
      return item;
   endfunction

   task automatic send_item(input req_type item);
      int gap;
      gap = idling_on ? $urandom_range(0, MAX_WAIT) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_replies.push_back(step_responder(item));
      items_sent++;
   endtask

   task automatic send_cmd(input logic [7:0] value);
      req_type item;
      item = random_item(OP_CMD);
      item.cmd_byte = value;
      send_item(item);
   endtask

   task automatic send_attn();
      send_item(random_item(OP_ATTN));
   endtask

   task automatic send_report(input logic [1:0] buttons, input logic [7:0] dx,
                              input logic [7:0] dy);
      req_type item;
      item = random_item(OP_REPORT);
      item.report_buttons = buttons;
      item.report_dx      = dx;
      item.report_dy      = dy;
      send_item(item);
   endtask

   task automatic send_frame(input bit interleave);
      repeat ($urandom_range(0, 4)) send_item(random_report());
      send_attn();
      send_cmd(BYTE_ADDR);
      send_cmd(BYTE_READ);
      for (int k = 0; k < 5; k++) begin
         // reports landing between data bytes, around the latch point too
         if (interleave && $urandom_range(0, 2) == 0) begin
            send_item(random_report());
         end
         send_cmd(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic send_broken_frame();
      logic [7:0] wrong;
      send_attn();
      case ($urandom_range(0, 3))
         0: begin
            do wrong = 8'($urandom_range(0, 255)); while (wrong == BYTE_ADDR);
            send_cmd(wrong);
         end
         1: begin
            send_cmd(BYTE_ADDR);
            do wrong = 8'($urandom_range(0, 255)); while (wrong == BYTE_READ);
            send_cmd(wrong);
         end
         2: begin
            send_cmd(BYTE_ADDR);
            send_cmd(BYTE_READ);
            repeat ($urandom_range(0, 4)) send_cmd(8'($urandom_range(0, 255)));
            send_attn();
         end
         default: begin
            // bytes after an abort must be ignored until attention drops
            do wrong = 8'($urandom_range(0, 255)); while (wrong == BYTE_ADDR);
            send_cmd(wrong);
            send_cmd(BYTE_ADDR);
            send_cmd(BYTE_READ);
         end
      endcase
   endtask

   task automatic test_wait_state_and_unused();
      req_type item;
      idling_on = 1'b1;
      send_cmd(BYTE_ADDR);
      item = '1;
      item.op = OP_UNUSED;
      send_item(item);
   endtask

   task automatic test_saturation_and_frame();
      idling_on = 1'b0;
      send_report(2'b11, 8'h7F, 8'h80);
      send_report(2'b01, 8'h7F, 8'h80);
      send_report(2'b01, 8'h80, 8'h7F);
      send_report(2'b11, 8'h00, 8'h00);
      send_attn();
      send_cmd(BYTE_ADDR);
      send_cmd(BYTE_READ);
      repeat (5) send_cmd(8'h00);
      send_attn();
   endtask

   task automatic test_frame_aborts();
      idling_on = 1'b1;
      send_attn();
      send_cmd(8'h00);
      send_attn();
      send_cmd(BYTE_ADDR);
      send_cmd(8'h43);
      send_attn();
      send_cmd(BYTE_ADDR);
      send_cmd(BYTE_READ);
      send_cmd(8'hAA);
      send_cmd(8'h55);
      send_attn();
   endtask

   task automatic test_random_traffic();
      int kind;
      int start;
      start = items_effective;
      while (items_effective - start < RANDOM_ITEMS) begin
         idling_on = ($urandom_range(0, 3) != 0);
         kind = $urandom_range(0, 9);
         if (kind < 7) begin
            send_frame(kind < 3);
         end else if (kind < 9) begin
            send_broken_frame();
         end else begin
            repeat ($urandom_range(1, 6)) send_item(random_item(2'($urandom_range(0, 3))));
         end
      end
   endtask

   // result side back-pressure
   initial begin
      int stall;
      rsp_ready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         stall = idling_on ? $urandom_range(0, MAX_WAIT) : 0;
         repeat (stall) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_replies.size() == 0) begin
            report_mismatch("unexpected item", rsp_data.tx_byte, 8'h00);
         end else begin
            want = expected_replies.pop_front();
            replies_checked++;
            if (rsp_data.ack !== want.ack) begin
               report_mismatch("ack", 8'(rsp_data.ack), 8'(want.ack));
            end
            if (rsp_data.tx_byte !== want.tx_byte) begin
               report_mismatch("tx_byte", rsp_data.tx_byte, want.tx_byte);
            end
            if (rsp_data.led !== want.led) begin
               report_mismatch("led", 8'(rsp_data.led), 8'(want.led));
            end
            if (rsp_data.frame_done !== want.frame_done) begin
               report_mismatch("frame_done", 8'(rsp_data.frame_done),
                               8'(want.frame_done));
            end
         end
      end
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      idling_on = 1'b0;
      clear_predictor();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_wait_state_and_unused();
      test_saturation_and_frame();
      test_frame_aborts();
      test_random_traffic();

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d items (%0d not ignored), checked %0d results",
               items_sent, items_effective, replies_checked);
      $display("read frames: %0d completed, %0d cut short; %0d mismatches",
               reads_completed, reads_aborted, error_count);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #(LIMIT_NS);
      $display("timeout with %0d results still pending", expected_replies.size());
      $display("Verification failed");
      $finish;
   end

endmodule
